// ===== src/lrts_pkg.sv =====
// Package for the longest-remaining-time scheduler.
// Holds the command and status codes, the task table entry type and widths.
// No dependencies.
package lrts_pkg;

  localparam int unsigned MaxTasksDef = 16;

  localparam int unsigned IdW    = 8;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned ClockW = 32;
  localparam int unsigned SumW   = 40;
  localparam int unsigned CountW = 5;

  // Word widths on the two stream sides.
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 192;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_ADDED = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RAN   = 2'd2,
    STAT_IDLE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [TimeW-1:0] remaining;
    logic [TimeW-1:0] burst;
    logic [TimeW-1:0] arrival;
    logic [IdW-1:0]   task_id;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Best candidate found by a table scan.
  typedef struct packed {
    logic   found;
    entry_t entry;
  } best_t;

endpackage

// ===== src/longest_remaining_time_scheduler.sv =====
// Longest-remaining-time-first scheduler: top level with the sequencer,
// result register and stream ports. Uses lrts_pkg, lrts_ram and lrts_scan.
//
// Usage:
//   Each input word carries a command in s_axis_tuser. An add stores the
//   task in the next free table slot, or reports that the table is full.
//   A tick scans the table for the ready task with the most remaining time,
//   serves it for one tick and advances the clock; it reports an idle tick
//   when nothing is ready. Every input word yields exactly one output word,
//   with the status in m_axis_tuser.
//   An add goes from acceptance to the result registers, then to the
//   output register. A tick sweeps the task table through its single
//   read port, one slot per cycle, then updates the served entry and, for
//   a finished task, works out waiting time and totals. One word is worked
//   on at a time; the next is taken in the cycle after a result is registered.
//   A finished result waits in the output register while the next word is
//   taken in and worked on; that word waits for the register to be free
//   only at its very end, so a stalled receiver holds back at most one word.
//   Reset clears the counters, clock and totals; the table itself needs no
//   clearing, since only slots below the loaded count are ever read.
module longest_remaining_time_scheduler #(
  parameter int unsigned MAX_TASKS = lrts_pkg::MaxTasksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] task_id, [23:8] arrival_time, [39:24] burst_time
  input  logic [lrts_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] command
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] ran_id, [8] finished, [40:9] completion_time, [72:41] turnaround,
  // [104:73] waiting, [144:105] total_turnaround, [184:145] total_waiting,
  // [189:185] finished_count, [190] all_done, [191] zero
  output logic [lrts_pkg::OutDataW-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]                    m_axis_tuser
);
  import lrts_pkg::*;

  localparam int unsigned IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam logic [ClockW-1:0] ClockMax = '1;
  localparam logic [SumW-1:0]   SumMax   = '1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_CALC   = 6'b001000,
    ST_ACCUM  = 6'b010000,
    ST_RESP   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]   loaded_q, loaded_d;
  logic [CntW-1:0]   done_q, done_d;
  logic [CntW-1:0]   scan_q, scan_d;
  logic [ClockW-1:0] clock_q, clock_d;
  logic [SumW-1:0]   sum_tat_q, sum_tat_d;
  logic [SumW-1:0]   sum_wt_q, sum_wt_d;
  logic              rd_valid_q, rd_valid_d;
  logic [IdxW-1:0]   rd_idx_q;

  status_e           res_status_q, res_status_d;
  logic [IdW-1:0]    res_id_q, res_id_d;
  logic              res_fin_q, res_fin_d;
  logic [ClockW-1:0] res_ct_q, res_ct_d;
  logic [ClockW-1:0] res_tat_q, res_tat_d;
  logic [ClockW-1:0] res_wt_q, res_wt_d;

  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic [1:0]          m_user_q, m_user_d;

  logic            in_fire;
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata, ram_rdata, new_entry;
  logic            scan_clear;
  best_t           best;
  logic [IdxW-1:0] best_idx;
  logic [ClockW-1:0] clock_next;
  logic [TimeW-1:0]  rem_next;
  logic [ClockW-1:0] arr_ext, burst_ext;
  logic [SumW:0]     sum_tat_add, sum_wt_add;
  logic [CntW+CountW-1:0] done_ext;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    new_entry.task_id   = s_axis_tdata[IdW-1:0];
    new_entry.arrival   = s_axis_tdata[IdW +: TimeW];
    new_entry.burst     = s_axis_tdata[IdW+TimeW +: TimeW];
    if (new_entry.burst == '0) begin
      new_entry.burst = TimeW'(1);
    end
    new_entry.remaining = new_entry.burst;
  end

  lrts_ram #(
    .Depth (MAX_TASKS),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  lrts_scan #(
    .IdxW (IdxW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (scan_clear),
    .valid_i    (rd_valid_q),
    .idx_i      (rd_idx_q),
    .entry_i    (ram_rdata),
    .clock_i    (clock_q),
    .best_o     (best),
    .best_idx_o (best_idx)
  );

  assign clock_next  = (clock_q == ClockMax) ? clock_q : clock_q + ClockW'(1);
  assign rem_next    = best.entry.remaining - TimeW'(1);
  assign arr_ext     = {{(ClockW-TimeW){1'b0}}, best.entry.arrival};
  assign burst_ext   = {{(ClockW-TimeW){1'b0}}, best.entry.burst};
  assign sum_tat_add = {1'b0, sum_tat_q} + {{(SumW-ClockW+1){1'b0}}, res_tat_q};
  assign sum_wt_add  = {1'b0, sum_wt_q} + {{(SumW-ClockW+1){1'b0}}, res_wt_q};
  assign done_ext    = {{CountW{1'b0}}, done_q};

  always_comb begin
    state_d      = state_q;
    loaded_d     = loaded_q;
    done_d       = done_q;
    scan_d       = scan_q;
    clock_d      = clock_q;
    sum_tat_d    = sum_tat_q;
    sum_wt_d     = sum_wt_q;
    rd_valid_d   = 1'b0;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_fin_d    = res_fin_q;
    res_ct_d     = res_ct_q;
    res_tat_d    = res_tat_q;
    res_wt_d     = res_wt_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = loaded_q[IdxW-1:0];
    ram_wdata    = new_entry;
    scan_clear   = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_id_d  = '0;
          res_fin_d = 1'b0;
          res_ct_d  = '0;
          res_tat_d = '0;
          res_wt_d  = '0;
          if (s_axis_tuser == CMD_ADD) begin
            if (loaded_q < CntW'(MAX_TASKS)) begin
              ram_we       = 1'b1;
              loaded_d     = loaded_q + CntW'(1);
              res_status_d = STAT_ADDED;
            end else begin
              res_status_d = STAT_FULL;
            end
            state_d = ST_RESP;
          end else begin
            scan_clear = 1'b1;
            scan_d     = '0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Reads run one slot ahead of the comparison; the sweep ends once
        // the last read word has been compared.
        if (scan_q < loaded_q) begin
          ram_re     = 1'b1;
          rd_valid_d = 1'b1;
          scan_d     = scan_q + CntW'(1);
        end else if (!rd_valid_q) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        clock_d = clock_next;
        state_d = ST_RESP;
        if (best.found) begin
          ram_we                = 1'b1;
          ram_waddr             = best_idx;
          ram_wdata             = best.entry;
          ram_wdata.remaining   = rem_next;
          res_status_d          = STAT_RAN;
          res_id_d              = best.entry.task_id;
          if (rem_next == '0) begin
            res_fin_d = 1'b1;
            res_ct_d  = clock_next;
            res_tat_d = (clock_next >= arr_ext) ? clock_next - arr_ext : '0;
            done_d    = done_q + CntW'(1);
            state_d   = ST_CALC;
          end
        end else begin
          res_status_d = STAT_IDLE;
        end
      end
      ST_CALC: begin
        res_wt_d  = (res_tat_q >= burst_ext) ? res_tat_q - burst_ext : '0;
        sum_tat_d = sum_tat_add[SumW] ? SumMax : sum_tat_add[SumW-1:0];
        state_d   = ST_ACCUM;
      end
      ST_ACCUM: begin
        sum_wt_d = sum_wt_add[SumW] ? SumMax : sum_wt_add[SumW-1:0];
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = res_status_q;
          m_data_d  = {1'b0, (done_q == loaded_q), done_ext[CountW-1:0],
                       sum_wt_q, sum_tat_q, res_wt_q, res_tat_q, res_ct_q,
                       res_fin_q, res_id_q};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      loaded_q   <= '0;
      done_q     <= '0;
      scan_q     <= '0;
      clock_q    <= '0;
      sum_tat_q  <= '0;
      sum_wt_q   <= '0;
      rd_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      loaded_q   <= loaded_d;
      done_q     <= done_d;
      scan_q     <= scan_d;
      clock_q    <= clock_d;
      sum_tat_q  <= sum_tat_d;
      sum_wt_q   <= sum_wt_d;
      rd_valid_q <= rd_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= scan_q[IdxW-1:0];
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_fin_q    <= res_fin_d;
    res_ct_q     <= res_ct_d;
    res_tat_q    <= res_tat_d;
    res_wt_q     <= res_wt_d;
    m_data_q     <= m_data_d;
    m_user_q     <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q <= loaded_q) && (loaded_q <= CntW'(MAX_TASKS)))
    else $error("finished or loaded count out of range");

  a_clock_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clock_q >= $past(clock_q))
    else $error("scheduler clock went backward");

  a_finish_means_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[IdW]) |-> (m_user_q == STAT_RAN))
    else $error("finished flag set on a word that served no task");

  a_scan_reads_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (scan_q < loaded_q))
    else $error("table read beyond the loaded slots");

endmodule

// ===== src/lrts_ram.sv =====
// Task table memory of the scheduler: one write port, one read port.
// Read data is registered, in the cycle after the read request. Uses lrts_pkg.
module lrts_ram #(
  parameter int unsigned Depth = lrts_pkg::MaxTasksDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  lrts_pkg::entry_t      wdata_i,
  input  logic                  re_i,
  input  logic [AddrW-1:0]      raddr_i,
  output lrts_pkg::entry_t      rdata_o
);
  import lrts_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lrts_scan.sv =====
// Selection stage of the scheduler: compares one table word per cycle
// against the best ready task seen so far. Uses lrts_pkg.
module lrts_scan #(
  parameter int unsigned IdxW = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        valid_i,
  input  logic [IdxW-1:0]             idx_i,
  input  lrts_pkg::entry_t            entry_i,
  input  logic [lrts_pkg::ClockW-1:0] clock_i,
  output lrts_pkg::best_t             best_o,
  output logic [IdxW-1:0]             best_idx_o
);
  import lrts_pkg::*;

  logic            found_q, found_d;
  entry_t          entry_q, entry_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            ready;
  logic            better;

  // A task is ready once it has arrived and still needs service. Ties on
  // remaining time go to the smaller id; full ties keep the earlier slot.
  assign ready = ({{(ClockW-TimeW){1'b0}}, entry_i.arrival} <= clock_i) &&
                 (entry_i.remaining != '0);
  assign better = !found_q ||
                  (entry_i.remaining > entry_q.remaining) ||
                  ((entry_i.remaining == entry_q.remaining) &&
                   (entry_i.task_id < entry_q.task_id));

  always_comb begin
    found_d = found_q;
    entry_d = entry_q;
    idx_d   = idx_q;
    if (clear_i) begin
      found_d = 1'b0;
    end else if (valid_i && ready && better) begin
      found_d = 1'b1;
      entry_d = entry_i;
      idx_d   = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    idx_q   <= idx_d;
  end

  assign best_o     = {found_q, entry_q};
  assign best_idx_o = idx_q;

endmodule

// ===== verif/tb_longest_remaining_time_scheduler.sv =====
// Testbench for longest_remaining_time_scheduler: drives add and tick words with
// random idling on both stream sides and checks every result word against a
// local predictor of the task table. Depends on lrts_pkg and the scheduler RTL.
module tb_longest_remaining_time_scheduler;
  import lrts_pkg::*;

  localparam int unsigned MaxTasks   = MaxTasksDef;
  localparam int unsigned DoneCycles = 64;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemCount  = 1050;
  localparam int unsigned PhaseLen   = 350;

  // Expected contents of one result word.
  typedef struct packed {
    status_e             status;
    logic [IdW-1:0]      ran_id;
    logic                finished;
    logic [ClockW-1:0]   completion;
    logic [ClockW-1:0]   turnaround;
    logic [ClockW-1:0]   waiting;
    logic [SumW-1:0]     total_turnaround;
    logic [SumW-1:0]     total_waiting;
    logic [CountW-1:0]   finished_count;
    logic                all_done;
  } sched_result_t;

  class sched_scoreboard;
    entry_t            slots [MaxTasks];
    int unsigned       loaded;
    int unsigned       done_cnt;
    logic [ClockW-1:0] clock_now;
    logic [SumW-1:0]   sum_turnaround;
    logic [SumW-1:0]   sum_waiting;
    sched_result_t     expected_q [$];
    int unsigned       errors;

    function new();
      loaded         = 0;
      done_cnt       = 0;
      clock_now      = '0;
      sum_turnaround = '0;
      sum_waiting    = '0;
      errors         = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [SumW-1:0] got, logic [SumW-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    function logic [SumW-1:0] add_saturated(logic [SumW-1:0] a, logic [ClockW-1:0] b);
      logic [SumW:0] s;
      s = {1'b0, a} + b;
      return s[SumW] ? '1 : s[SumW-1:0];
    endfunction

    // Runs one accepted input word through the task table and queues its result.
    function void note_word(cmd_e cmd, logic [IdW-1:0] id, logic [TimeW-1:0] arr,
                            logic [TimeW-1:0] bur);
      sched_result_t     r;
      logic              found;
      int unsigned       best;
      logic [ClockW-1:0] t;
      logic [ClockW-1:0] w;
      r = '0;
      if (cmd == CMD_ADD) begin
        if (loaded >= MaxTasks) begin
          r.status = STAT_FULL;
        end else begin
          slots[loaded].task_id   = id;
          slots[loaded].arrival   = arr;
          slots[loaded].burst     = (bur == '0) ? TimeW'(1) : bur;
          slots[loaded].remaining = slots[loaded].burst;
          loaded++;
          r.status = STAT_ADDED;
        end
      end else begin
        found = 1'b0;
        best  = 0;
        for (int i = 0; i < loaded; i++) begin
          if (ClockW'(slots[i].arrival) <= clock_now && slots[i].remaining != '0) begin
            if (!found || slots[i].remaining > slots[best].remaining) begin
              best  = i;
              found = 1'b1;
            end else if (slots[i].remaining == slots[best].remaining &&
                         slots[i].task_id < slots[best].task_id) begin
              best = i;
            end
          end
        end
        if (clock_now != '1) clock_now++;
        if (found) begin
          r.status = STAT_RAN;
          r.ran_id = slots[best].task_id;
          slots[best].remaining--;
          if (slots[best].remaining == '0) begin
            t = (clock_now >= ClockW'(slots[best].arrival)) ?
                clock_now - ClockW'(slots[best].arrival) : '0;
            w = (t >= ClockW'(slots[best].burst)) ? t - ClockW'(slots[best].burst) : '0;
            r.finished     = 1'b1;
            r.completion   = clock_now;
            r.turnaround   = t;
            r.waiting      = w;
            sum_turnaround = add_saturated(sum_turnaround, t);
            sum_waiting    = add_saturated(sum_waiting, w);
            done_cnt++;
          end
        end else begin
          r.status = STAT_IDLE;
        end
      end
      r.total_turnaround = sum_turnaround;
      r.total_waiting    = sum_waiting;
      r.finished_count   = CountW'(done_cnt);
      r.all_done         = (done_cnt == loaded);
      expected_q.push_back(r);
    endfunction

    task check_word(logic [1:0] status, logic [OutDataW-1:0] data);
      sched_result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("result word with no expectation waiting");
        return;
      end
      e = expected_q.pop_front();
      compare_field("status", status, e.status);
      compare_field("ran_id", data[7:0], e.ran_id);
      compare_field("finished", data[8], e.finished);
      compare_field("completion_time", data[40:9], e.completion);
      compare_field("turnaround", data[72:41], e.turnaround);
      compare_field("waiting", data[104:73], e.waiting);
      compare_field("total_turnaround", data[144:105], e.total_turnaround);
      compare_field("total_waiting", data[184:145], e.total_waiting);
      compare_field("finished_count", data[189:185], e.finished_count);
      compare_field("all_done", data[190], e.all_done);
      compare_field("pad bit", data[191], 1'b0);
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  int unsigned     send_idle   = 18;
  int unsigned     recv_idle   = 81;
  int unsigned     cycle_count = 0;
  sched_scoreboard sb          = new();

  longest_remaining_time_scheduler #(
    .MAX_TASKS(MaxTasks)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tuser, m_axis_tdata);
  end

  // Presents one word from a falling edge on and notes it once it is taken.
  task automatic send_word(input cmd_e cmd, input logic [IdW-1:0] id,
                           input logic [TimeW-1:0] arr, input logic [TimeW-1:0] bur);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {bur, arr, id};
    s_axis_tuser  = cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(cmd, id, arr, bur);
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly ticks, with adds of short tasks arriving by or soon after the current
  // clock while the table has room; adds to a full table carry fully random fields.
  task automatic random_word();
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] arr;
    logic [TimeW-1:0] bur;
    id  = IdW'($urandom_range(255));
    arr = TimeW'($urandom_range(65535));
    bur = TimeW'($urandom_range(65535));
    if (sb.loaded < MaxTasks && $urandom_range(99) < 25) begin
      if ($urandom_range(1)) id = IdW'($urandom_range(7));
      if ($urandom_range(1)) arr = sb.clock_now[TimeW-1:0] + TimeW'($urandom_range(30));
      else arr = TimeW'($urandom_range(sb.clock_now[TimeW-1:0]));
      bur = TimeW'($urandom_range(40));
      send_word(CMD_ADD, id, arr, bur);
    end else if (sb.loaded >= MaxTasks && $urandom_range(99) < 12) begin
      send_word(CMD_ADD, id, arr, bur);
    end else begin
      send_word(CMD_TICK, id, arr, bur);
    end
  endtask

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int k;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Idle tick on an empty table, then a zero burst task that finishes at once.
    send_word(CMD_TICK, '0, '0, '0);
    send_word(CMD_ADD, 8'hff, '0, '0);
    send_word(CMD_TICK, '0, '0, '0);
    // A task that never arrives, twin tasks with the same id and burst, a tie
    // broken by the smaller id, and a longer task arriving later that preempts.
    send_word(CMD_ADD, 8'h00, 16'hffff, 16'hffff);
    send_word(CMD_ADD, 8'd9, 16'd0, 16'd3);
    send_word(CMD_ADD, 8'd9, 16'd0, 16'd3);
    send_word(CMD_ADD, 8'd4, 16'd3, 16'd3);
    send_word(CMD_ADD, 8'd20, 16'd4, 16'd5);
    repeat (15) send_word(CMD_TICK, '0, '0, '0);

    for (k = 23; k < ItemCount; k++) begin
      if (k == PhaseLen) begin
        wait_all_results();
        send_idle = 81;
        recv_idle = 18;
      end
      if (k == 2 * PhaseLen) begin
        wait_all_results();
        send_idle = 0;
        recv_idle = 0;
      end
      random_word();
    end

    wait_all_results();
    repeat (DoneCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
